[hdl/rftm_pkg.sv]
// Shared constants, widths and the gamma table for the filmic tone mapper.
// Used by rftm_lane, rftm_luma and rgbe_filmic_tone_map_core. No dependencies.
`default_nettype none

package rftm_pkg;

  // Fixed-point formats
  localparam int FRAC      = 16;               // fraction bits of channel values
  localparam int GTB       = 10;               // gamma table address bits
  localparam int INT_BITS  = 16;
  localparam int VAL_W     = INT_BITS + FRAC;  // Q16.F channel value
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 16;
  localparam int GSH_W     = VAL_W + GAIN_W - GAIN_FRAC;
  localparam int EXP_BIAS  = 136;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
  localparam logic [VAL_W-1:0]  SAT_MAX    = {VAL_W{1'b1}};
  localparam logic [FRAC-1:0]   K_SIX      = FRAC'(((64'd1 << FRAC) * 6 + 5) / 10);

  // Curve input below 8.0 fits in X_W bits; at or above it the curve is one
  localparam int X_W   = FRAC + 3;
  localparam int SQ_W  = 2 * X_W;
  localparam int ND_W  = 2 * X_W + 9;
  localparam int REM_W = ND_W + 1;
  localparam int T_W   = FRAC + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC;

  // Shift of the decode step: e - EXP_BIAS + FRAC
  localparam int SH_W = 10;
  localparam logic signed [SH_W-1:0] SH_OFS = SH_W'(EXP_BIAS - FRAC);

  // Gamma table
  localparam int GIDX_W = GTB + 1;
  localparam int GN     = 1 << GTB;
  localparam int BIG_W  = 144;

  // Lane pipeline: decode, gain, scale, square, num/den, divider, table read
  localparam int LANE_LAT = 5 + (FRAC + 1) + 1;
  localparam int LUMA_LAT = 3;
  localparam int PIPE_LAT = LANE_LAT + LUMA_LAT;

  // Luma divide by 1000 through a reciprocal and one correction step
  localparam int SUM_W      = 18;
  localparam int LUMA_SH    = 22;
  localparam int LUMA_RECIP = (1 << LUMA_SH) / 1000;
  localparam int QE_W       = SUM_W + 13;

  typedef logic [7:0] gamma_lut_t [GN+1];

  // Entry i: largest v in 0..255 with v^9 * GN^5 <= i^5 * 255^9, exact
  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    logic [8:0] v;
    logic [8:0] cand;
    for (int i = 0; i <= GN; i++) begin
      rhs = BIG_W'(1);
      for (int k = 0; k < 5; k++) rhs = rhs * BIG_W'(i);
      for (int k = 0; k < 9; k++) rhs = rhs * BIG_W'(255);
      v = 9'd0;
      for (int b = 7; b >= 0; b--) begin
        cand = v | (9'd1 << b);
        lhs = BIG_W'(1);
        for (int k = 0; k < 9; k++) lhs = lhs * BIG_W'(cand);
        for (int k = 0; k < 5; k++) lhs = lhs * BIG_W'(GN);
        if (lhs <= rhs) v = cand;
      end
      lut[i] = v[7:0];
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

`default_nettype wire

[hdl/rftm_lane.sv]
// One color channel: RGBE decode, gain, 0.6 scale, filmic curve, gamma ROM.
// Depends on rftm_pkg. Pure datapath, advanced by a shared enable.
`default_nettype none

module rftm_lane
  import rftm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [7:0]        mantissa,
  input  wire logic [7:0]        exponent,
  input  wire logic [GAIN_W-1:0] gain,
  output logic      [7:0]        byte_out
);

  // Stage 1: decode m * 2^(e-136) into Q16.F with saturation
  logic signed [SH_W-1:0] sh;
  logic [SH_W-1:0]        neg;
  logic [VAL_W+7:0]       wide;
  logic [VAL_W-1:0]       dec;
  logic [VAL_W-1:0]       dec_q;

  always_comb begin
    sh   = $signed({2'b00, exponent}) - SH_OFS;
    neg  = -sh;
    wide = (VAL_W+8)'(mantissa) << sh[5:0];
    if (!sh[SH_W-1]) begin
      if (sh > SH_W'(VAL_W)) begin
        dec = (mantissa != 8'd0) ? SAT_MAX : '0;
      end else if (wide[VAL_W+7:VAL_W] != 8'd0) begin
        dec = SAT_MAX;
      end else begin
        dec = wide[VAL_W-1:0];
      end
    end else if (neg >= SH_W'(8)) begin
      dec = '0;
    end else begin
      dec = VAL_W'(mantissa >> neg[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) dec_q <= dec;
  end

  // Stage 2: exposure gain, Q8.16, saturated
  logic [VAL_W+GAIN_W-1:0] gprod;
  logic [GSH_W-1:0]        gsh;
  logic [VAL_W-1:0]        gain_q;

  assign gprod = (VAL_W+GAIN_W)'(dec_q) * (VAL_W+GAIN_W)'(gain);
  assign gsh   = gprod[VAL_W+GAIN_W-1:GAIN_FRAC];

  always_ff @(posedge clk) begin
    if (en) gain_q <= (gsh[GSH_W-1:VAL_W] != '0) ? SAT_MAX : gsh[VAL_W-1:0];
  end

  // Stage 3: scale by 0.6, flag values past the curve limit
  logic [VAL_W+FRAC-1:0] sprod;
  logic [VAL_W-1:0]      xs;
  logic [X_W-1:0]        x3;
  logic                  big3;

  assign sprod = (VAL_W+FRAC)'(gain_q) * (VAL_W+FRAC)'(K_SIX);
  assign xs    = sprod[VAL_W+FRAC-1:FRAC];

  always_ff @(posedge clk) begin
    if (en) begin
      x3   <= xs[X_W-1:0];
      big3 <= (xs[VAL_W-1:X_W] != '0);
    end
  end

  // Stage 4: square
  logic [X_W-1:0]  x4;
  logic [SQ_W-1:0] sq4;
  logic            big4;

  always_ff @(posedge clk) begin
    if (en) begin
      x4   <= x3;
      sq4  <= SQ_W'(x3) * SQ_W'(x3);
      big4 <= big3;
    end
  end

  // Stage 5: numerator and denominator of the curve
  logic [ND_W-1:0] xf;
  logic [ND_W-1:0] num5;
  logic [ND_W-1:0] den5;
  logic            big5;

  assign xf = ND_W'(x4) << FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      num5 <= ND_W'(251) * ND_W'(sq4) + ND_W'(3) * xf;
      den5 <= ND_W'(243) * ND_W'(sq4) + ND_W'(59) * xf + (ND_W'(14) << (2 * FRAC));
      big5 <= big4;
    end
  end

  // Divider: one quotient bit per stage, integer bit first
  logic [REM_W-1:0] rem_q [FRAC+1];
  logic [ND_W-1:0]  den_q [FRAC+1];
  logic [T_W-1:0]   quo_q [FRAC+1];
  logic             big_q [FRAC+1];

  for (genvar j = 0; j <= FRAC; j++) begin : g_div
    logic [REM_W-1:0] r_sh;
    logic [ND_W-1:0]  d_in;
    logic             b_in;
    logic [T_W-1:0]   q_in;
    logic             qbit;

    if (j == 0) begin : g_first
      assign r_sh = REM_W'(num5);
      assign d_in = den5;
      assign b_in = big5;
      assign q_in = '0;
    end else begin : g_next
      assign r_sh = {rem_q[j-1][REM_W-2:0], 1'b0};
      assign d_in = den_q[j-1];
      assign b_in = big_q[j-1];
      assign q_in = {quo_q[j-1][T_W-2:0], 1'b0};
    end

    assign qbit = (r_sh >= REM_W'(d_in));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= qbit ? (r_sh - REM_W'(d_in)) : r_sh;
        den_q[j] <= d_in;
        quo_q[j] <= q_in | T_W'(qbit);
        big_q[j] <= b_in;
      end
    end
  end

  // Clamp to one, form table address, registered ROM read
  logic [T_W-1:0]     t;
  logic [T_W+GTB-1:0] t_ext;
  logic [GIDX_W-1:0]  gidx;

  always_comb begin
    if (big_q[FRAC] || (quo_q[FRAC] > T_ONE)) begin
      t = T_ONE;
    end else begin
      t = quo_q[FRAC];
    end
    t_ext = (T_W+GTB)'(t) << GTB;
    gidx  = GIDX_W'(t_ext >> FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) byte_out <= GAMMA_LUT[gidx];
  end

endmodule

`default_nettype wire

[hdl/rftm_luma.sv]
// Merge stage: registers the three channel bytes and adds the truncated luma.
// Depends on rftm_pkg. Three pipeline stages, advanced by a shared enable.
`default_nettype none

module rftm_luma
  import rftm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  output logic      [7:0] red_out,
  output logic      [7:0] green_out,
  output logic      [7:0] blue_out,
  output logic      [7:0] luma_out
);

  // Stage A: weighted sum
  logic [SUM_W-1:0] sum_a;
  logic [7:0]       r_a, g_a, b_a;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_a <= SUM_W'(299) * SUM_W'(red_in) + SUM_W'(587) * SUM_W'(green_in)
             + SUM_W'(114) * SUM_W'(blue_in);
      r_a   <= red_in;
      g_a   <= green_in;
      b_a   <= blue_in;
    end
  end

  // Stage B: reciprocal estimate, low by at most one
  logic [QE_W-1:0]  qprod;
  logic [SUM_W-1:0] sum_b;
  logic [7:0]       qe_b;
  logic [7:0]       r_b, g_b, b_b;

  assign qprod = QE_W'(sum_a) * QE_W'(LUMA_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_b <= sum_a;
      qe_b  <= 8'(qprod >> LUMA_SH);
      r_b   <= r_a;
      g_b   <= g_a;
      b_b   <= b_a;
    end
  end

  // Stage C: correction and output register
  logic [SUM_W-1:0] rem_b;

  assign rem_b = sum_b - SUM_W'(qe_b) * SUM_W'(1000);

  always_ff @(posedge clk) begin
    if (en) begin
      luma_out  <= (rem_b >= SUM_W'(1000)) ? (qe_b + 8'd1) : qe_b;
      red_out   <= r_b;
      green_out <= g_b;
      blue_out  <= b_b;
    end
  end

endmodule

`default_nettype wire

[hdl/rgbe_filmic_tone_map_core.sv]
// Top level of the RGBE filmic tone mapper: gain register, three channel
// lanes, luma merge stage and the valid/ready pipeline control.
// Depends on rftm_pkg, rftm_lane and rftm_luma.
//
// Usage:
//   Input channel in_valid/in_ready carries one RGBE pixel per request
//   (three mantissas, shared exponent, frame_last). Output channel
//   out_valid/out_ready returns one request per pixel: three gamma corrected
//   bytes, their luma and a copy of frame_last, in input order.
//   The user must write the exposure gain (Q8.16) by gain_wr_en/gain_wr_data
//   while the block is idle; the block does not enforce this. The gain takes
//   effect for pixels accepted afterwards. Stages: 5 arithmetic, 17 divider
//   (one quotient bit each), the gamma ROM read and 3 luma (PIPE_LAT total).
//   Throughput: one pixel per cycle unless stalled; three lanes in parallel.
//   Reset clears all valid flags and sets the gain to one (65536).
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops until out_ready returns.
`default_nettype none

module rgbe_filmic_tone_map_core
  import rftm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              gain_wr_en,
  input  wire logic [GAIN_W-1:0] gain_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        red_mantissa,
  input  wire logic [7:0]        green_mantissa,
  input  wire logic [7:0]        blue_mantissa,
  input  wire logic [7:0]        shared_exponent,
  input  wire logic              frame_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        red_out,
  output logic      [7:0]        green_out,
  output logic      [7:0]        blue_out,
  output logic      [7:0]        luma_out,
  output logic                   frame_last_out
);

  // Exposure gain register
  logic [GAIN_W-1:0] exposure_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain <= GAIN_RESET;
    end else if (gain_wr_en) begin
      exposure_gain <= gain_wr_data;
    end
  end

  // Pipeline advance: hold only while the last stage waits on the receiver
  logic en;
  logic vld [PIPE_LAT];
  logic fl  [PIPE_LAT];

  assign en        = !vld[PIPE_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PIPE_LAT-1];
  assign frame_last_out = fl[PIPE_LAT-1];

  // Valid and frame_last travel alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= frame_last;
      for (int i = 1; i < PIPE_LAT; i++) fl[i] <= fl[i-1];
    end
  end

  // Channel lanes
  logic [7:0] red_byte, green_byte, blue_byte;

  rftm_lane u_red (
    .clk      (clk),
    .en       (en),
    .mantissa (red_mantissa),
    .exponent (shared_exponent),
    .gain     (exposure_gain),
    .byte_out (red_byte)
  );

  rftm_lane u_green (
    .clk      (clk),
    .en       (en),
    .mantissa (green_mantissa),
    .exponent (shared_exponent),
    .gain     (exposure_gain),
    .byte_out (green_byte)
  );

  rftm_lane u_blue (
    .clk      (clk),
    .en       (en),
    .mantissa (blue_mantissa),
    .exponent (shared_exponent),
    .gain     (exposure_gain),
    .byte_out (blue_byte)
  );

  // Merge: luma and output registers
  rftm_luma u_luma (
    .clk       (clk),
    .en        (en),
    .red_in    (red_byte),
    .green_in  (green_byte),
    .blue_in   (blue_byte),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .luma_out  (luma_out)
  );

endmodule

`default_nettype wire
